/* sv/hscd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_pkg: shared constants and types of the shot change detector
// Bin geometry, counter widths, register indexes and the command and status
// records between the controller and the datapath.
// ----------------------------------------------------------------------------
package hscd_pkg;

  localparam int LEVELS_PER_CHANNEL = 8;
  localparam int MAX_FRAME_PIXELS   = 4194304;

  localparam int NUM_BINS = LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL;
  localparam int LVL_W    = $clog2(LEVELS_PER_CHANNEL);
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int CNT_W    = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int ACC_W    = 32;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 17;
  localparam int FIELD_W  = 23;
  localparam int PROD_W   = THR_W + CNT_W;
  localparam int CMP_W    = ACC_W + 16;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(58982);
  localparam logic [TIME_W-1:0] MIN_SHOT_RESET  = TIME_W'(1000);
  localparam logic [TIME_W-1:0] FIRST_DLY_RESET = TIME_W'(500);

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_PIXELS);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MIN_SHOT  = 2'd1,
    REG_FIRST_DLY = 2'd2
  } reg_index_t;

  typedef enum logic {
    EV_FIRST_SHOT = 1'b0,
    EV_NEW_SHOT   = 1'b1
  } event_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic              accept;   // pixel request taken, issue the bin read
    logic              update;   // write back the incremented bin
    logic              clear;    // zero both histograms at sweep_addr
    logic              sweep;    // read both, zero the older one at sweep_addr
    logic              decide;   // evaluate the frame and switch sides
    logic              load;     // load the result register
    event_kind_t       kind;
    logic              last;
    logic [BIN_W-1:0]  sweep_addr;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic eof;       // the pixel being written closes a frame
    logic ev_first;  // the frame produced a first-shot event
    logic ev_new;    // the frame produced a new-shot event
    logic out_free;  // the result register can take a value
  } status_t;

  function automatic logic [LVL_W-1:0] chan_level(input logic [7:0] c);
    logic [31:0] p;
    p = 32'(c) * 32'(LEVELS_PER_CHANNEL);
    return LVL_W'(p >> 8);
  endfunction

endpackage

/* sv/hscd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_if: request channels of the shot change detector
// The pixel channel and the result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface hscd_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic        end_of_frame;
  logic [31:0] frame_time_ms;

  modport source (output valid, blue, green, red, end_of_frame, frame_time_ms,
                  input ready);
  modport sink   (input valid, blue, green, red, end_of_frame, frame_time_ms,
                  output ready);
endinterface

interface hscd_res_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [31:0] shot_start_ms;
  logic [31:0] previous_length_ms;
  logic [22:0] overlap_count;
  logic [22:0] frame_pixels;
  logic        last;

  modport source (output valid, event_kind, shot_start_ms, previous_length_ms,
                  overlap_count, frame_pixels, last, input ready);
  modport sink   (input valid, event_kind, shot_start_ms, previous_length_ms,
                  overlap_count, frame_pixels, last, output ready);
endinterface

/* sv/histogram_shot_change_detector.sv */
`timescale 1ns / 1ps
// A plain pixel is a bin read, then a write-back of the incremented count. A frame-end
// pixel goes on with the sweep of all bins, the last add, the decision and the emit of
// its results. No new pixel is taken until the write-back of the last one is done,
// nor while a frame end is handled or its results wait on a stalled output. Reset:
// synchronous; a clearing pass of both histograms follows with no pixel taken. Config
// writes are always taken.
// ----------------------------------------------------------------------------
// histogram_shot_change_detector: color histogram shot change detector
// Counts BGR pixels into ping-pong histograms and reports shot events from
// the histogram intersection of consecutive frames.
// ----------------------------------------------------------------------------
module histogram_shot_change_detector (
  input  logic        clk,
  input  logic        rst,
  hscd_pix_if.sink    pix_in,
  hscd_res_if.source  res_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // The controller only sequences; every stored value of the frame lives in
  // the datapath. The two talk through one command and one status record.
  hscd_pkg::cmd_t    cmd;
  hscd_pkg::status_t st;
  logic              in_ready;

  assign pix_in.ready = in_ready;

  // The controller owns the sweep address, which serves both the clearing
  // pass after reset and the intersection sweep at each frame end.
  hscd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds both histogram memories, the frame counters, the
  // configuration registers and the result register that feeds the output.
  // The result register is loaded only when it is empty or being taken, so
  // a stalled sink simply holds the sequencer in its emit state.
  hscd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .blue          (pix_in.blue),
    .green         (pix_in.green),
    .red           (pix_in.red),
    .end_of_frame  (pix_in.end_of_frame),
    .frame_time_ms (pix_in.frame_time_ms),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .res           (res_out)
  );

endmodule

/* sv/hscd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_ctrl: sequencer of the shot change detector
// Runs the clearing pass, the per-pixel read-modify-write, the frame sweep
// and the emission of up to two results.
// ----------------------------------------------------------------------------
module hscd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hscd_pkg::status_t  st,
  output hscd_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_SWEEP,
    S_FINISH,
    S_DECIDE,
    S_EMIT_FIRST,
    S_EMIT_NEW
  } state_t;

  state_t                       state;
  logic [hscd_pkg::BIN_W-1:0]   addr;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.sweep_addr = addr;
    cmd.kind       = hscd_pkg::EV_FIRST_SHOT;
    case (state)
      S_CLEAR:  cmd.clear  = 1'b1;
      S_IDLE:   cmd.accept = in_valid;
      S_UPDATE: cmd.update = 1'b1;
      S_SWEEP:  cmd.sweep  = 1'b1;
      S_DECIDE: cmd.decide = 1'b1;
      S_EMIT_FIRST: begin
        cmd.load = st.ev_first && st.out_free;
        cmd.last = !st.ev_new;
      end
      S_EMIT_NEW: begin
        cmd.load = st.out_free;
        cmd.kind = hscd_pkg::EV_NEW_SHOT;
        cmd.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == hscd_pkg::BIN_LAST) begin
            addr  <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) state <= S_UPDATE;
        end
        S_UPDATE: begin
          addr  <= '0;
          state <= st.eof ? S_SWEEP : S_IDLE;
        end
        S_SWEEP: begin
          addr <= addr + 1'b1;
          if (addr == hscd_pkg::BIN_LAST) begin
            addr  <= '0;
            state <= S_FINISH;
          end
        end
        S_FINISH: state <= S_DECIDE;
        S_DECIDE: state <= S_EMIT_FIRST;
        S_EMIT_FIRST: begin
          if (!st.ev_first) begin
            state <= st.ev_new ? S_EMIT_NEW : S_IDLE;
          end else if (st.out_free) begin
            state <= st.ev_new ? S_EMIT_NEW : S_IDLE;
          end
        end
        S_EMIT_NEW: begin
          if (st.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/hscd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hscd_datapath: histograms, frame state and result register
// Two bin memories, the intersection accumulator, the cut test and the
// configuration registers.
// ----------------------------------------------------------------------------
module hscd_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  hscd_pkg::cmd_t               cmd,
  output hscd_pkg::status_t            st,
  input  logic [7:0]                   blue,
  input  logic [7:0]                   green,
  input  logic [7:0]                   red,
  input  logic                         end_of_frame,
  input  logic [31:0]                  frame_time_ms,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  hscd_res_if.source                   res
);

  localparam int BW = hscd_pkg::BIN_W;
  localparam int CW = hscd_pkg::CNT_W;
  localparam int AW = hscd_pkg::ACC_W;
  localparam int TW = hscd_pkg::TIME_W;
  localparam int FW = hscd_pkg::FIELD_W;

  logic [CW-1:0] mem0 [hscd_pkg::NUM_BINS];
  logic [CW-1:0] mem1 [hscd_pkg::NUM_BINS];
  logic [CW-1:0] rd0, rd1;

  logic [hscd_pkg::THR_W-1:0] threshold;
  logic [TW-1:0]              min_shot;
  logic [TW-1:0]              first_dly;

  logic                        side;
  logic [CW-1:0]               pix_count;
  logic [TW-1:0]               last_cut;
  logic                        shot_seen;
  logic [BW-1:0]               bin_addr;
  logic                        eof;
  logic [TW-1:0]               frame_t;
  logic                        sweep_d;
  logic [AW-1:0]               acc;
  logic [hscd_pkg::PROD_W-1:0] prod;
  logic                        ev_first, ev_new;
  logic [FW-1:0]               ev_overlap, ev_pix;
  logic [TW-1:0]               ev_len, ev_t;

  logic [BW-1:0]  bin_calc;
  logic [BW-1:0]  raddr;
  logic [CW-1:0]  cur_rd, inc_val, min_val;
  logic           we0, we1;
  logic [BW-1:0]  waddr;
  logic [CW-1:0]  wdata;
  logic [TW-1:0]  len_c;
  logic           cut_c, first_c, new_c;
  logic           out_free;

  assign bin_calc = BW'(hscd_pkg::chan_level(blue))
                  + BW'(hscd_pkg::chan_level(green)) * BW'(hscd_pkg::LEVELS_PER_CHANNEL)
                  + BW'(hscd_pkg::chan_level(red))
                    * BW'(hscd_pkg::LEVELS_PER_CHANNEL * hscd_pkg::LEVELS_PER_CHANNEL);

  assign raddr   = cmd.accept ? bin_calc : cmd.sweep_addr;
  assign cur_rd  = side ? rd1 : rd0;
  assign inc_val = (cur_rd < hscd_pkg::CNT_MAX) ? cur_rd + 1'b1 : cur_rd;
  assign min_val = (rd0 < rd1) ? rd0 : rd1;

  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = cmd.sweep_addr;
    wdata = '0;
    if (cmd.update) begin
      waddr = bin_addr;
      wdata = inc_val;
      we0   = !side;
      we1   = side;
    end else if (cmd.clear) begin
      we0 = 1'b1;
      we1 = 1'b1;
    end else if (cmd.sweep) begin
      // The older histogram is zeroed right behind its read.
      we0 = side;
      we1 = !side;
    end
  end

  always_ff @(posedge clk) begin
    rd0 <= mem0[raddr];
    rd1 <= mem1[raddr];
    if (we0) mem0[waddr] <= wdata;
    if (we1) mem1[waddr] <= wdata;
  end

  assign len_c   = (frame_t >= last_cut) ? frame_t - last_cut : '0;
  assign cut_c   = {acc, 16'b0} < hscd_pkg::CMP_W'(prod);
  assign first_c = !shot_seen && (frame_t > first_dly);
  assign new_c   = cut_c && (len_c > min_shot);

  assign out_free    = !res.valid || res.ready;
  assign st.eof      = eof;
  assign st.ev_first = ev_first;
  assign st.ev_new   = ev_new;
  assign st.out_free = out_free;

  always_ff @(posedge clk) begin
    prod <= hscd_pkg::PROD_W'(threshold) * hscd_pkg::PROD_W'(pix_count);
    if (cmd.accept) begin
      bin_addr <= bin_calc;
      eof      <= end_of_frame;
      frame_t  <= frame_time_ms;
      acc      <= '0;
    end
    if (sweep_d) acc <= acc + AW'(min_val);
    if (cmd.decide) begin
      ev_overlap <= FW'(acc);
      ev_pix     <= FW'(pix_count);
      ev_len     <= len_c;
      ev_t       <= frame_t;
    end
    if (cmd.load) begin
      res.event_kind         <= cmd.kind;
      res.shot_start_ms      <= (cmd.kind == hscd_pkg::EV_NEW_SHOT) ? ev_t : '0;
      res.previous_length_ms <= (cmd.kind == hscd_pkg::EV_NEW_SHOT) ? ev_len : '0;
      res.overlap_count      <= ev_overlap;
      res.frame_pixels       <= ev_pix;
      res.last               <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= hscd_pkg::THRESHOLD_RESET;
      min_shot  <= hscd_pkg::MIN_SHOT_RESET;
      first_dly <= hscd_pkg::FIRST_DLY_RESET;
      side      <= 1'b0;
      pix_count <= '0;
      last_cut  <= '0;
      shot_seen <= 1'b0;
      sweep_d   <= 1'b0;
      ev_first  <= 1'b0;
      ev_new    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      sweep_d <= cmd.sweep;
      if (cfg_we) begin
        case (cfg_index)
          hscd_pkg::REG_THRESHOLD: threshold <= cfg_data[hscd_pkg::THR_W-1:0];
          hscd_pkg::REG_MIN_SHOT:  min_shot  <= cfg_data;
          hscd_pkg::REG_FIRST_DLY: first_dly <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.update && pix_count < hscd_pkg::CNT_MAX) pix_count <= pix_count + 1'b1;
      if (cmd.decide) begin
        ev_first <= first_c;
        ev_new   <= new_c;
        if (first_c || new_c) shot_seen <= 1'b1;
        if (cut_c) last_cut <= frame_t;
        side      <= !side;
        pix_count <= '0;
      end
      if (cmd.load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the histogram shot change detector
// Feeds frames of BGR pixel requests with frame-end times, predicts the shot
// events from its own histogram model, and compares every result request
// field by field while both channels stall at random until the last stretch.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        eof;
    logic [31:0] t_ms;
  } pixel_req_t;

  typedef struct {
    hscd_pkg::event_kind_t kind;
    logic [31:0] start_ms;
    logic [31:0] length_ms;
    logic [22:0] overlap;
    logic [22:0] pixels;
    logic        last;
  } shot_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  hscd_pix_if pix();
  hscd_res_if res();

  histogram_shot_change_detector uut (
    .clk(clk), .rst(rst), .pix_in(pix.sink), .res_out(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block: two ping-pong histograms plus the shot tracker.
  logic [22:0] hist_shadow [2][hscd_pkg::NUM_BINS];
  logic        side_shadow = 1'b0;
  logic [22:0] pixel_total = '0;
  logic [31:0] last_cut_ms = '0;
  logic        shot_reported = 1'b0;
  logic [16:0] thr_q16 = hscd_pkg::THRESHOLD_RESET;
  logic [31:0] min_shot_ms = hscd_pkg::MIN_SHOT_RESET;
  logic [31:0] first_dly_ms = hscd_pkg::FIRST_DLY_RESET;

  pixel_req_t  pixel_queue[$];
  shot_event_t shot_events_due[$];

  int   mismatches = 0;
  bit   idling_on = 1'b1;
  bit   hold_request = 1'b0;
  int   src_gap = 0;
  int   snk_stall = 0;
  int   hold_cycles = 0;
  logic [31:0] clock_ms = 0;

  initial begin
    for (int s = 0; s < 2; s++)
      for (int b = 0; b < hscd_pkg::NUM_BINS; b++)
        hist_shadow[s][b] = '0;
  end

  // Counts one pixel into the live histogram; on a frame end it evaluates the
  // intersection and queues the events that the frame causes.
  task automatic count_pixel(input pixel_req_t p);
    int unsigned bin;
    logic [31:0] overlap_sum;
    logic [31:0] span;
    logic [63:0] lhs, rhs;
    bit          is_cut;
    shot_event_t ev;
    int          n_ev;
    begin
      bin = hscd_pkg::chan_level(p.blue)
          + hscd_pkg::chan_level(p.green) * hscd_pkg::LEVELS_PER_CHANNEL
          + hscd_pkg::chan_level(p.red) * hscd_pkg::LEVELS_PER_CHANNEL
            * hscd_pkg::LEVELS_PER_CHANNEL;
      if (hist_shadow[side_shadow][bin] < hscd_pkg::MAX_FRAME_PIXELS)
        hist_shadow[side_shadow][bin] = hist_shadow[side_shadow][bin] + 1;
      if (pixel_total < hscd_pkg::MAX_FRAME_PIXELS) pixel_total = pixel_total + 1;
      if (p.eof) begin
        overlap_sum = 0;
        for (int b = 0; b < hscd_pkg::NUM_BINS; b++)
          overlap_sum += (hist_shadow[0][b] < hist_shadow[1][b]) ?
                         hist_shadow[0][b] : hist_shadow[1][b];
        span = (p.t_ms >= last_cut_ms) ? p.t_ms - last_cut_ms : 32'd0;
        lhs = 64'(overlap_sum) * 64'd65536;
        rhs = 64'(thr_q16) * 64'(pixel_total);
        is_cut = lhs < rhs;
        n_ev = 0;
        if (!shot_reported && p.t_ms > first_dly_ms) begin
          ev = '{hscd_pkg::EV_FIRST_SHOT, 32'd0, 32'd0, overlap_sum[22:0], pixel_total,
                 1'b0};
          shot_events_due.push_back(ev);
          n_ev++;
          shot_reported = 1'b1;
        end
        if (is_cut) begin
          if (span > min_shot_ms) begin
            ev = '{hscd_pkg::EV_NEW_SHOT, p.t_ms, span, overlap_sum[22:0], pixel_total,
                   1'b0};
            shot_events_due.push_back(ev);
            n_ev++;
            shot_reported = 1'b1;
          end
          last_cut_ms = p.t_ms;
        end
        // Only the final event of a frame end carries last.
        if (n_ev > 0) shot_events_due[$].last = 1'b1;
        side_shadow = ~side_shadow;
        for (int b = 0; b < hscd_pkg::NUM_BINS; b++) hist_shadow[side_shadow][b] = '0;
        pixel_total = '0;
      end
    end
  endtask

  // Pixel driver: holds the request until taken, then pulls the next one.
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      pix.blue <= '0;
      pix.green <= '0;
      pix.red <= '0;
      pix.end_of_frame <= 1'b0;
      pix.frame_time_ms <= '0;
    end else if (!pix.valid || pix.ready) begin
      if (pix.valid && pix.ready)
        count_pixel('{pix.blue, pix.green, pix.red, pix.end_of_frame, pix.frame_time_ms});
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        pix.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        pixel_req_t p;
        p = pixel_queue.pop_front();
        pix.blue <= p.blue;
        pix.green <= p.green;
        pix.red <= p.red;
        pix.end_of_frame <= p.eof;
        pix.frame_time_ms <= p.t_ms;
        pix.valid <= 1'b1;
        if (idling_on && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 15);
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each taken result with the oldest expectation,
  // and drives ready with random stalls and one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (shot_events_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: kind %0d start %0d",
                                         res.event_kind, res.shot_start_ms);
        end else begin
          shot_event_t ev;
          ev = shot_events_due.pop_front();
          if (res.event_kind !== ev.kind || res.shot_start_ms !== ev.start_ms ||
              res.previous_length_ms !== ev.length_ms ||
              res.overlap_count !== ev.overlap || res.frame_pixels !== ev.pixels ||
              res.last !== ev.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind %0d start %0d len %0d ovl %0d pix %0d last %0d",
                       ev.kind, ev.start_ms, ev.length_ms, ev.overlap, ev.pixels, ev.last,
                       "\n          got kind %0d start %0d len %0d ovl %0d pix %0d last %0d",
                       res.event_kind, res.shot_start_ms, res.previous_length_ms,
                       res.overlap_count, res.frame_pixels, res.last);
          end
        end
      end
      if (hold_request && hold_cycles == 0) begin
        hold_cycles <= 3000;
        hold_request <= 1'b0;
        res.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        res.ready <= (hold_cycles == 1);
      end else if (snk_stall > 0) begin
        snk_stall <= snk_stall - 1;
        res.ready <= (snk_stall == 1);
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        snk_stall <= $urandom_range(1, 15);
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input hscd_pkg::reg_index_t idx, input logic [31:0] value);
    begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= value;
      @(posedge clk);
      cfg_we <= 1'b0;
      case (idx)
        hscd_pkg::REG_THRESHOLD: thr_q16 = value[16:0];
        hscd_pkg::REG_MIN_SHOT:  min_shot_ms = value;
        default:                 first_dly_ms = value;
      endcase
    end
  endtask

  // Builds one frame around a base color; spread 255 gives fully random bytes.
  task automatic push_frame(input int n_pix, input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r, input int spread, input logic [31:0] t);
    pixel_req_t p;
    begin
      for (int i = 0; i < n_pix; i++) begin
        p.blue = b + 8'($urandom_range(0, spread));
        p.green = g + 8'($urandom_range(0, spread));
        p.red = r + 8'($urandom_range(0, spread));
        p.eof = (i == n_pix - 1);
        p.t_ms = p.eof ? t : $urandom;
        pixel_queue.push_back(p);
      end
    end
  endtask

  // Waits until every request is taken and every result is in, then lets a
  // full bin sweep pass in case the last frame end caused no result.
  task automatic settle();
    begin
      wait (pixel_queue.size() == 0 && !pix.valid && shot_events_due.size() == 0);
      repeat (600) @(posedge clk);
    end
  endtask

  // Random scenes: runs of similar frames, hard scene changes, noisy frames and
  // the odd random clock jump, until the requested pixel count is queued.
  task automatic random_scenes(input int n_items);
    logic [7:0] b, g, r;
    int sent;
    int n;
    begin
      sent = 0;
      b = $urandom; g = $urandom; r = $urandom;
      while (sent < n_items) begin
        case ($urandom_range(0, 9))
          0, 1, 2:  begin b = $urandom; g = $urandom; r = $urandom; end
          3:        clock_ms = $urandom;
          default:  ;
        endcase
        clock_ms += $urandom_range(0, 1500);
        n = $urandom_range(1, 30);
        push_frame(n, b, g, r, ($urandom_range(0, 7) == 0) ? 255 : 20, clock_ms);
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset values: channel extremes, times at and just past
    // the first-shot delay, the largest frame time and a clock running backwards.
    push_frame(3, 8'd0, 8'd0, 8'd0, 0, 32'd0);
    push_frame(3, 8'd255, 8'd255, 8'd255, 0, 32'd500);
    push_frame(2, 8'd0, 8'd255, 8'd0, 0, 32'd501);
    push_frame(2, 8'd255, 8'd0, 8'd255, 0, 32'd2000);
    push_frame(1, 8'd31, 8'd32, 8'd224, 0, 32'hFFFF_FFFF);
    push_frame(2, 8'd128, 8'd64, 8'd0, 0, 32'd10);
    push_frame(2, 8'd128, 8'd64, 8'd0, 0, 32'd5000);
    push_frame(3, 8'd0, 8'd0, 8'd255, 0, 32'd9000);
    settle();

    // Maximal threshold with no minimum length: every change is reported whose frame time lies past the last cut.
    write_reg(hscd_pkg::REG_THRESHOLD, 32'd65536);
    write_reg(hscd_pkg::REG_MIN_SHOT, 32'd0);
    write_reg(hscd_pkg::REG_FIRST_DLY, 32'hFFFF_FFFF);
    clock_ms = 0;
    hold_request = 1'b1;
    random_scenes(500);
    settle();

    // The sender pauses here until everything is in, then a threshold of zero
    // and the largest minimum length: nothing can be reported.
    write_reg(hscd_pkg::REG_THRESHOLD, 32'd0);
    write_reg(hscd_pkg::REG_MIN_SHOT, 32'hFFFF_FFFF);
    write_reg(hscd_pkg::REG_FIRST_DLY, 32'd0);
    random_scenes(300);
    settle();

    // Reset-like settings with register data carrying high bits beyond the
    // threshold width.
    write_reg(hscd_pkg::REG_THRESHOLD, 32'hFFFE_E666);
    write_reg(hscd_pkg::REG_MIN_SHOT, 32'd800);
    write_reg(hscd_pkg::REG_FIRST_DLY, 32'd0);
    random_scenes(600);
    settle();

    // Last stretch without idling on either side.
    idling_on = 1'b0;
    write_reg(hscd_pkg::REG_THRESHOLD, 32'($urandom_range(30000, 65536)));
    write_reg(hscd_pkg::REG_MIN_SHOT, 32'($urandom_range(0, 1200)));
    random_scenes(500);
    settle();

    if (mismatches == 0) begin
      $display("PASS histogram_shot_change_detector");
    end else begin
      $display("FAIL histogram_shot_change_detector");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL histogram_shot_change_detector");
    $finish;
  end

endmodule

/* files.f */
sv/hscd_pkg.sv
sv/hscd_if.sv
sv/hscd_ctrl.sv
sv/hscd_datapath.sv
sv/histogram_shot_change_detector.sv
tb/tb_top.sv
